### src/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared widths, request mode codes and character constants of the text
// console cell writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int MODE_W = 3;
	localparam int VAL_W  = 32;
	localparam int ATTR_W = 8;
	localparam int CHAR_W = 8;
	localparam int IDX_W  = 11;
	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;

	localparam int DEFAULT_COLUMNS = 80;
	localparam int DEFAULT_ROWS    = 25;

	localparam int BCD_DIGITS = 10;
	localparam int DIG_W      = 4 * BCD_DIGITS;
	localparam int CNT_W      = $clog2(BCD_DIGITS + 1);

	localparam logic [MODE_W-1:0] MODE_PUT  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_LINE = 3'd1;
	localparam logic [MODE_W-1:0] MODE_DEC  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_HEX  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_HOME = 3'd4;

	localparam logic [CHAR_W-1:0] CHAR_CURSOR  = 8'h7C;
	localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_X       = 8'h78;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;

	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd15;
	localparam logic [ATTR_W-1:0] ATTR_BLINK = 8'h80;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
		logic [CHAR_W-1:0] dw;
		dw = {4'h0, d};
		if (d < 4'd10) begin
			return CHAR_ZERO + dw;
		end
		return CHAR_UPPER_A + dw - 8'd10;
	endfunction

endpackage

### src/tcw_if.sv
// ----------------------------------------------------------------------------
// tcw_if
// Valid/ready channels of the text console cell writer: requests, cell
// writes and the default attribute register write.
// ----------------------------------------------------------------------------
interface tcw_req_if
	import tcw_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [VAL_W-1:0]  value;
	logic [ATTR_W-1:0] attr;
	logic              use_default_attr;

	modport source (output valid, mode, value, attr, use_default_attr, input ready);
	modport sink (input valid, mode, value, attr, use_default_attr, output ready);
endinterface

interface tcw_cell_if
	import tcw_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  cell_index;
	logic [CHAR_W-1:0] char_code;
	logic [ATTR_W-1:0] cell_attr;
	logic              last;

	modport source (output valid, cell_index, char_code, cell_attr, last, input ready);
	modport sink (input valid, cell_index, char_code, cell_attr, last, output ready);
endinterface

interface tcw_cfg_if
	import tcw_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [ATTR_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

### src/tcw_dabble.sv
// ----------------------------------------------------------------------------
// tcw_dabble
// Bit-serial binary to BCD converter: one input bit per cycle is shifted
// into the decimal digits, each digit corrected by add-three beforehand.
// ----------------------------------------------------------------------------
module tcw_dabble
	import tcw_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [VAL_W-1:0] bin,
	output logic             done,
	output logic [DIG_W-1:0] bcd
);

	localparam int STEP_W = $clog2(VAL_W + 1);

	logic [VAL_W-1:0]  bin_q;
	logic [DIG_W-1:0]  bcd_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [DIG_W-1:0]  adj;

	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(VAL_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= bin;
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= bin_q << 1;
			bcd_q <= {adj[DIG_W-2:0], bin_q[VAL_W-1]};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

### src/text_console_cell_writer.sv
// ----------------------------------------------------------------------------
// text_console_cell_writer
// Keeps the console cursor and turns each request into a run of cell
// writes, each printed character followed by a blinking cursor mark.
//
//   channel | role   | carries
//   --------+--------+------------------------------------------------
//   req     | sink   | mode, value, attr, use_default_attr
//   cfg     | sink   | data (default attribute)
//   wr      | source | cell_index, char_code, cell_attr, last
//
// A request is taken only when the previous one has finished. A plain
// character is a cell write followed by a cursor mark, and each character
// of a number is a select step, a cell write and a cursor mark. A decimal
// request first passes through bit-serial conversion and leading zero
// removal, and a hex request through leading zero removal.
// Reset homes the cursor and sets the default attribute to 15. A stall on
// the cell channel holds the sequencer in place.
// ----------------------------------------------------------------------------
module text_console_cell_writer
	import tcw_pkg::*;
#(
	parameter int COLUMNS = DEFAULT_COLUMNS,
	parameter int ROWS    = DEFAULT_ROWS
) (
	input  logic       clk,
	input  logic       arst_n,
	tcw_req_if.sink    req,
	tcw_cfg_if.sink    cfg,
	tcw_cell_if.source wr
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CONV = 3'd1;
	localparam logic [2:0] ST_SKIP = 3'd2;
	localparam logic [2:0] ST_NEXT = 3'd3;
	localparam logic [2:0] ST_PUT  = 3'd4;
	localparam logic [2:0] ST_MARK = 3'd5;
	localparam logic [2:0] ST_LINE = 3'd6;
	localparam logic [2:0] ST_HOME = 3'd7;

	localparam logic [1:0] PFX_NONE = 2'd0;
	localparam logic [1:0] PFX_X    = 2'd1;
	localparam logic [1:0] PFX_ZERO = 2'd2;

	localparam int FULL_W = ROW_W + COL_W;

	logic [2:0]        state_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [1:0]        pfx_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [ATTR_W-1:0] default_attr_q;
	logic [CHAR_W-1:0] char_q;
	logic [ATTR_W-1:0] attr_q;
	logic [DIG_W-1:0]  dig_q;

	logic              cell_valid_q;
	logic [IDX_W-1:0]  cell_index_q;
	logic [CHAR_W-1:0] char_code_q;
	logic [ATTR_W-1:0] cell_attr_q;
	logic              last_q;

	logic              req_fire;
	logic              out_free;
	logic              emit;
	logic              is_nl;
	logic              mark_last;
	logic              skip_shift;
	logic              dab_start;
	logic              dab_done;
	logic [DIG_W-1:0]  dab_bcd;
	logic [FULL_W-1:0] idx_full;
	logic [ROW_W-1:0]  row_adv;
	logic [COL_W-1:0]  col_adv;
	logic [CHAR_W-1:0] emit_char;
	logic [ATTR_W-1:0] emit_attr;
	logic              emit_last;
	logic [ATTR_W-1:0] mark_attr;

	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign req_fire  = req.valid && req.ready;
	assign out_free  = !cell_valid_q || wr.ready;
	assign is_nl     = (char_q == CHAR_NEWLINE);
	assign mark_last = (pfx_q == PFX_NONE) && (cnt_q == '0);
	assign mark_attr = default_attr_q | ATTR_BLINK;
	assign dab_start = req_fire && (req.mode == MODE_DEC);
	assign skip_shift = (dig_q[DIG_W-1 -: 4] == 4'h0) && (cnt_q > CNT_W'(1));
	assign emit = out_free && (state_q == ST_PUT || state_q == ST_MARK ||
		state_q == ST_LINE || state_q == ST_HOME);

	assign idx_full = FULL_W'(row_q) * FULL_W'(COLUMNS) + FULL_W'(col_q);

	tcw_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dab_start),
		.bin    (req.value),
		.done   (dab_done),
		.bcd    (dab_bcd)
	);

	always_comb begin
		row_adv = row_q;
		col_adv = col_q + 1'b1;
		if (is_nl || col_adv >= COL_W'(COLUMNS)) begin
			col_adv = '0;
			row_adv = row_q + 1'b1;
		end
		if (row_adv >= ROW_W'(ROWS)) begin
			row_adv = '0;
			col_adv = '0;
		end
	end

	always_comb begin
		emit_char = '0;
		emit_attr = '0;
		emit_last = 1'b0;
		unique case (state_q)
			ST_PUT: begin
				emit_char = is_nl ? '0 : char_q;
				emit_attr = is_nl ? '0 : attr_q;
			end
			ST_MARK: begin
				emit_char = CHAR_CURSOR;
				emit_attr = mark_attr;
				emit_last = mark_last;
			end
			ST_LINE: begin
				emit_last = 1'b1;
			end
			ST_HOME: begin
				emit_char = CHAR_CURSOR;
				emit_attr = mark_attr;
				emit_last = 1'b1;
			end
			default: begin
				emit_last = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			row_q          <= '0;
			col_q          <= '0;
			pfx_q          <= PFX_NONE;
			cnt_q          <= '0;
			default_attr_q <= ATTR_RESET;
			cell_valid_q   <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				default_attr_q <= cfg.data;
			end
			if (emit) begin
				cell_valid_q <= 1'b1;
			end else if (wr.ready) begin
				cell_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						unique case (req.mode)
							MODE_PUT: begin
								pfx_q   <= PFX_NONE;
								cnt_q   <= '0;
								state_q <= ST_PUT;
							end
							MODE_LINE: begin
								if (col_q != '0) begin
									state_q <= ST_LINE;
								end
							end
							MODE_DEC: begin
								state_q <= ST_CONV;
							end
							MODE_HEX: begin
								pfx_q   <= PFX_ZERO;
								cnt_q   <= CNT_W'(BCD_DIGITS);
								state_q <= ST_SKIP;
							end
							MODE_HOME: begin
								row_q   <= '0;
								col_q   <= '0;
								state_q <= ST_HOME;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_CONV: begin
					if (dab_done) begin
						pfx_q   <= PFX_NONE;
						cnt_q   <= CNT_W'(BCD_DIGITS);
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (skip_shift) begin
						cnt_q <= cnt_q - 1'b1;
					end else begin
						state_q <= ST_NEXT;
					end
				end
				ST_NEXT: begin
					if (pfx_q == PFX_ZERO) begin
						pfx_q <= PFX_X;
					end else if (pfx_q == PFX_X) begin
						pfx_q <= PFX_NONE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
					state_q <= ST_PUT;
				end
				ST_PUT: begin
					if (out_free) begin
						row_q   <= row_adv;
						col_q   <= col_adv;
						state_q <= ST_MARK;
					end
				end
				ST_MARK: begin
					if (out_free) begin
						state_q <= mark_last ? ST_IDLE : ST_NEXT;
					end
				end
				ST_LINE: begin
					if (out_free) begin
						row_q   <= row_adv;
						col_q   <= col_adv;
						state_q <= ST_IDLE;
					end
				end
				ST_HOME: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			char_q <= (req.mode == MODE_LINE) ? CHAR_NEWLINE : req.value[CHAR_W-1:0];
			attr_q <= req.use_default_attr ? default_attr_q : req.attr;
			dig_q  <= DIG_W'(req.value);
		end else if (state_q == ST_CONV && dab_done) begin
			dig_q <= dab_bcd;
		end else if (state_q == ST_SKIP && skip_shift) begin
			dig_q <= dig_q << 4;
		end else if (state_q == ST_NEXT) begin
			if (pfx_q == PFX_ZERO) begin
				char_q <= CHAR_ZERO;
			end else if (pfx_q == PFX_X) begin
				char_q <= CHAR_X;
			end else begin
				char_q <= digit_char(dig_q[DIG_W-1 -: 4]);
				dig_q  <= dig_q << 4;
			end
		end
		if (emit) begin
			cell_index_q <= idx_full[IDX_W-1:0];
			char_code_q  <= emit_char;
			cell_attr_q  <= emit_attr;
			last_q       <= emit_last;
		end
	end

	assign wr.valid      = cell_valid_q;
	assign wr.cell_index = cell_index_q;
	assign wr.char_code  = char_code_q;
	assign wr.cell_attr  = cell_attr_q;
	assign wr.last       = last_q;

endmodule

### tb/tcw_cell_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_cell_checker
// Watches the request, register and cell channels of the console writer.
// It keeps its own cursor and default attribute, works out the cell writes
// that each accepted request must produce, and compares every accepted cell
// write, field by field, with the oldest one still due.
// ----------------------------------------------------------------------------
module tcw_cell_checker
	import tcw_pkg::*;
#(
	parameter int COLUMNS = DEFAULT_COLUMNS,
	parameter int ROWS    = DEFAULT_ROWS
) (
	input  logic clk,
	input  logic arst_n,
	tcw_req_if   req,
	tcw_cfg_if   cfg,
	tcw_cell_if  wr,
	output int   mismatches,
	output int   outstanding
);

	localparam int HEX_DIGITS   = 8;
	localparam int SHOWN_ERRORS = 10;

	typedef struct packed {
		logic [IDX_W-1:0]  idx;
		logic [CHAR_W-1:0] ch;
		logic [ATTR_W-1:0] at;
		logic              last;
	} cell_write_t;

	cell_write_t       due_cells[$];
	cell_write_t       got;
	cell_write_t       want;
	int                cur_row;
	int                cur_col;
	logic [ATTR_W-1:0] dflt_attr;

	function automatic void write_cell(input logic [CHAR_W-1:0] ch, input logic [ATTR_W-1:0] at);
		cell_write_t w;
		w.idx = IDX_W'(cur_row * COLUMNS + cur_col);
		w.ch = ch;
		w.at = at;
		w.last = 1'b0;
		due_cells.push_back(w);
	endfunction

	function automatic void wrap_cursor();
		if (cur_col >= COLUMNS) begin
			cur_col = 0;
			cur_row++;
		end
		if (cur_row >= ROWS) begin
			cur_row = 0;
			cur_col = 0;
		end
	endfunction

	// A newline blanks the current cell instead of printing; either way the
	// blinking cursor mark lands on the new cursor position.
	function automatic void print_char(input logic [CHAR_W-1:0] ch, input logic [ATTR_W-1:0] at);
		if (ch == CHAR_NEWLINE) begin
			write_cell('0, '0);
			cur_col = 0;
			cur_row++;
		end else begin
			write_cell(ch, at);
			cur_col++;
		end
		wrap_cursor();
		write_cell(CHAR_CURSOR, dflt_attr | ATTR_BLINK);
	endfunction

	function automatic logic [CHAR_W-1:0] hex_glyph(input logic [3:0] d);
		logic [CHAR_W-1:0] dw;
		dw = {4'h0, d};
		return (d < 4'd10) ? CHAR_ZERO + dw : CHAR_UPPER_A + (dw - 8'd10);
	endfunction

	function automatic void console_request(input logic [MODE_W-1:0] mode,
			input logic [VAL_W-1:0] value, input logic [ATTR_W-1:0] at);
		logic [3:0]       digs[BCD_DIGITS];
		logic [VAL_W-1:0] v;
		int               nd;
		int               i;
		int               first;
		cell_write_t      tail;
		first = due_cells.size();
		v = value;
		nd = 0;
		case (mode)
			MODE_PUT: begin
				print_char(value[CHAR_W-1:0], at);
			end
			MODE_LINE: begin
				if (cur_col != 0) begin
					write_cell('0, '0);
					cur_col = 0;
					cur_row++;
					wrap_cursor();
				end
			end
			MODE_DEC: begin
				do begin
					digs[nd] = 4'(v % 10);
					v = v / 10;
					nd++;
				end while (v != 0 && nd < BCD_DIGITS);
				for (i = nd - 1; i >= 0; i--) begin
					print_char(CHAR_ZERO + {4'h0, digs[i]}, at);
				end
			end
			MODE_HEX: begin
				print_char(CHAR_ZERO, at);
				print_char(CHAR_X, at);
				do begin
					digs[nd] = v[3:0];
					v = v >> 4;
					nd++;
				end while (v != 0 && nd < HEX_DIGITS);
				for (i = nd - 1; i >= 0; i--) begin
					print_char(hex_glyph(digs[i]), at);
				end
			end
			MODE_HOME: begin
				cur_row = 0;
				cur_col = 0;
				write_cell(CHAR_CURSOR, dflt_attr | ATTR_BLINK);
			end
			default: begin
			end
		endcase
		if (due_cells.size() > first) begin
			tail = due_cells.pop_back();
			tail.last = 1'b1;
			due_cells.push_back(tail);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_row = 0;
			cur_col = 0;
			dflt_attr = ATTR_RESET;
			due_cells.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				dflt_attr = cfg.data;
			end
			if (req.valid && req.ready) begin
				console_request(req.mode, req.value,
					req.use_default_attr ? dflt_attr : req.attr);
			end
			if (wr.valid && wr.ready) begin
				got = {wr.cell_index, wr.char_code, wr.cell_attr, wr.last};
				if (due_cells.size() == 0) begin
					mismatches++;
					if (mismatches <= SHOWN_ERRORS) begin
						$display("cell write with none due: ",
							"index %0d char %02h attr %02h last %0b",
							got.idx, got.ch, got.at, got.last);
					end
				end else begin
					want = due_cells.pop_front();
					if (got.idx != want.idx || got.ch != want.ch || got.at != want.at ||
							got.last != want.last) begin
						mismatches++;
						if (mismatches <= SHOWN_ERRORS) begin
							$display("cell write mismatch: expected ",
								"index %0d char %02h attr %02h last %0b, ",
								want.idx, want.ch, want.at, want.last,
								"got index %0d char %02h attr %02h last %0b",
								got.idx, got.ch, got.at, got.last);
						end
					end
				end
			end
			outstanding = due_cells.size();
		end
	end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the text console cell writer. A directed run covers every
// request mode, newlines, blank line starts, number extremes and unused
// modes; then random requests follow under several default attributes,
// with random gaps on the request side and stalls on the cell side.
// ----------------------------------------------------------------------------
module tb_top;
	import tcw_pkg::*;

	localparam int COLUMNS       = DEFAULT_COLUMNS;
	localparam int ROWS          = DEFAULT_ROWS;
	localparam int STALL_PCT     = 22;
	localparam int QUIET_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 100;
	localparam int PHASE_ITEMS   = 100;

	localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
	localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

	logic clk;
	logic arst_n;
	bit   gaps_on;
	int   mismatches;
	int   outstanding;
	int   quiet_cycles;

	tcw_req_if  req_ch ();
	tcw_cfg_if  cfg_ch ();
	tcw_cell_if cell_ch ();

	text_console_cell_writer #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.cfg   (cfg_ch),
		.wr    (cell_ch)
	);

	tcw_cell_checker #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.cfg        (cfg_ch),
		.wr         (cell_ch),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cell_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			cell_ch.ready <= !(gaps_on && $urandom_range(0, 99) < STALL_PCT);
		end
	end

	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (req_ch.valid && req_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
					(cell_ch.valid && cell_ch.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("status: fail");
		$finish;
	end

	task automatic send(input logic [MODE_W-1:0] mode, input logic [VAL_W-1:0] value,
			input logic [ATTR_W-1:0] attr, input logic use_dflt);
		while (gaps_on && $urandom_range(0, 99) < STALL_PCT) begin
			req_ch.valid <= 1'b0;
			req_ch.value <= $urandom;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.mode <= mode;
		req_ch.value <= value;
		req_ch.attr <= attr;
		req_ch.use_default_attr <= use_dflt;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_default_attr(input logic [ATTR_W-1:0] a);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= a;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic random_phase(input int count);
		int                sent;
		int                pick;
		logic [MODE_W-1:0] mode;
		logic [VAL_W-1:0]  value;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(0, 99);
			value = $urandom >> $urandom_range(0, 31);
			if (pick < 35) begin
				mode = MODE_PUT;
				value = $urandom;
				if ($urandom_range(0, 99) < 15) begin
					value[CHAR_W-1:0] = CHAR_NEWLINE;
				end
			end else if (pick < 45) begin
				mode = MODE_LINE;
			end else if (pick < 68) begin
				mode = MODE_DEC;
			end else if (pick < 90) begin
				mode = MODE_HEX;
			end else if (pick < 94) begin
				mode = MODE_HOME;
			end else begin
				mode = MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
			end
			send(mode, value, ATTR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			if (mode <= MODE_HOME) begin
				sent++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		gaps_on = 1'b1;
		req_ch.valid = 1'b0;
		req_ch.mode = MODE_PUT;
		req_ch.value = '0;
		req_ch.attr = '0;
		req_ch.use_default_attr = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send(MODE_PUT, {24'h0, CHAR_UPPER_A}, 8'h00, 1'b0);
		send(MODE_PUT, 32'h0000_00FF, 8'hFF, 1'b0);
		send(MODE_PUT, 32'h0000_0000, 8'h55, 1'b1);
		send(MODE_PUT, {24'h0, CHAR_NEWLINE}, 8'h12, 1'b0);
		send(MODE_LINE, 32'hFFFF_FFFF, 8'h34, 1'b0);
		send(MODE_DEC, 32'd0, 8'h3C, 1'b0);
		send(MODE_LINE, 32'h0, 8'h00, 1'b0);
		send(MODE_DEC, 32'hFFFF_FFFF, 8'hA5, 1'b0);
		send(MODE_DEC, 32'd1000000000, 8'h5A, 1'b1);
		send(MODE_DEC, 32'd100, 8'h01, 1'b0);
		send(MODE_HEX, 32'h0, 8'h80, 1'b0);
		send(MODE_HEX, 32'hFFFF_FFFF, 8'h7F, 1'b1);
		send(MODE_HEX, 32'h1000_0000, 8'hC3, 1'b0);
		send(MODE_HEX, 32'h0A0B_0C0D, 8'h3C, 1'b0);
		send(MODE_SPARE_LO, 32'h1234_5678, 8'h11, 1'b0);
		send(MODE_W'(6), 32'h8765_4321, 8'h22, 1'b1);
		send(MODE_SPARE_HI, 32'hFFFF_FFFF, 8'hFF, 1'b1);
		send(MODE_PUT, 32'h5A5A_5A0A, 8'h66, 1'b0);
		send(MODE_HOME, 32'h0, 8'h00, 1'b0);
		send(MODE_LINE, 32'h0, 8'h00, 1'b0);
		send(MODE_PUT, 32'hFFFF_FF7C, 8'hAA, 1'b0);
		send(MODE_LINE, 32'h0, 8'h00, 1'b1);

		drain();
		set_default_attr(8'h00);
		random_phase(PHASE_ITEMS);

		drain();
		set_default_attr(8'hFF);
		gaps_on = 1'b0;
		random_phase(PHASE_ITEMS);

		drain();
		gaps_on = 1'b1;
		set_default_attr(ATTR_W'($urandom_range(0, 255)));
		random_phase(PHASE_ITEMS);

		drain();
		set_default_attr(ATTR_W'($urandom_range(0, 255)));
		random_phase(PHASE_ITEMS);

		drain();
		if (mismatches == 0 && outstanding == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
